// ===== hw/rtl/paragraph_first_fit_allocator_macros.svh =====
// Assertion macros for the paragraph allocator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PARAGRAPH_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PARAGRAPH_FIRST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants of the paragraph allocator.
// No dependencies.
package pfa_pkg;

  localparam int MaxBlocks = 64;
  localparam int CntW      = $clog2(MaxBlocks + 1);

  localparam logic [16:0] TotalReset = 17'd40960;
  localparam logic [16:0] TotalMax   = 17'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOMEM   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INIT    = 7'b0000010,
    ST_ALIGN   = 7'b0000100,
    ST_SCAN    = 7'b0001000,
    ST_RESOLVE = 7'b0010000,
    ST_DRAIN   = 7'b0100000,
    ST_RESP    = 7'b1000000
  } state_e;

  // one table entry as it travels round the ring
  typedef struct packed {
    logic        vld;
    logic        first;
    logic        used;
    logic [16:0] start;
    logic [16:0] size;
  } ent_t;

  typedef struct packed {
    logic load;
    logic shift;
  } ring_ctl_t;

  localparam ent_t EntNone = '0;

endpackage

// ===== hw/rtl/pfa_cell.sv =====
// One ring cell: holds a table entry and takes its neighbour's on shift.
// Depends on pfa_pkg.
module pfa_cell import pfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_ctl_t ctl_i,
  input  ent_t      init_i,
  input  ent_t      d_i,
  output ent_t      q_o
);

  logic vld_q;
  ent_t pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.load) begin
      vld_q <= init_i.vld;
    end else if (ctl_i.shift) begin
      vld_q <= d_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pay_q <= init_i;
    end else if (ctl_i.shift) begin
      pay_q <= d_i;
    end
  end

  always_comb begin
    q_o     = pay_q;
    q_o.vld = vld_q;
  end

endmodule

// ===== hw/rtl/pfa_ctrl.sv =====
// Sequencer of the allocator: sees the ring head, feeds the ring tail.
// Holds a two-entry queue for merges and inserts. Depends on pfa_pkg.
module pfa_ctrl import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_i,
  input  logic        start_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] size_i,
  input  logic [15:0] seg_i,
  input  ent_t        head_i,
  output ring_ctl_t   ctl_o,
  output ent_t        tail_o,
  output logic        busy_o,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] seg_o
);

  state_e          state_q, state_d;
  logic            merge_q, merge_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            found_q, found_d;
  logic            wait_q, wait_d;
  ent_t            q0_q, q0_d, q1_q, q1_d;
  op_e             op_q;
  logic [15:0]     req_q, seg_q;
  status_e         status_q, status_d;
  logic [15:0]     segout_q, segout_d;
  logic            ld_cmd;

  logic [16:0] reqx, diff_up, diff_dn;
  logic [17:0] q0_end;
  logic        adj, full, last, fit, split;
  ent_t        sh_q0, sh_q1, alloc_new, rsz_new, xn, qn;

  assign reqx    = {1'b0, req_q};
  assign diff_up = reqx - q0_q.size;
  assign diff_dn = q0_q.size - reqx;
  assign q0_end  = {1'b0, q0_q.start} + {1'b0, q0_q.size};
  assign adj     = q0_end == {1'b0, head_i.start};
  assign full    = cnt_q == CntW'(MaxBlocks);
  assign last    = pos_q == CntW'(MaxBlocks - 1);
  assign fit     = !head_i.used && !head_i.start[16] && (reqx <= head_i.size);
  assign split   = reqx < head_i.size;

  // queue advance: head of queue leaves, incoming entry joins behind
  assign sh_q0 = q1_q.vld ? q1_q : head_i;
  assign sh_q1 = q1_q.vld ? head_i : EntNone;

  always_comb begin
    alloc_new       = EntNone;
    alloc_new.vld   = 1'b1;
    alloc_new.start = head_i.start + reqx;
    alloc_new.size  = head_i.size - reqx;
    rsz_new         = EntNone;
    rsz_new.vld     = 1'b1;
    rsz_new.start   = q0_q.start + reqx;
    rsz_new.size    = diff_dn;
  end

  always_comb begin
    state_d  = state_q;
    merge_d  = merge_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    found_d  = found_q;
    wait_d   = wait_q;
    q0_d     = q0_q;
    q1_d     = q1_q;
    status_d = status_q;
    segout_d = segout_q;
    ld_cmd   = 1'b0;
    ctl_o    = '0;
    tail_o   = head_i;
    xn       = head_i;
    qn       = q0_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_wr_i) begin
          state_d = ST_INIT;
        end else if (start_i) begin
          ld_cmd   = 1'b1;
          found_d  = 1'b0;
          wait_d   = 1'b0;
          segout_d = '0;
          case (op_e'(op_i))
            OP_ALLOC: begin
              status_d = STATUS_NOMEM;
              merge_d  = 1'b1;
              state_d  = ST_ALIGN;
            end
            OP_FREE: begin
              status_d = STATUS_INVALID;
              merge_d  = 1'b0;
              state_d  = ST_ALIGN;
            end
            OP_RESIZE: begin
              status_d = STATUS_INVALID;
              merge_d  = 1'b1;
              state_d  = ST_ALIGN;
            end
            default: begin
              status_d = STATUS_INVALID;
              state_d  = ST_RESP;
            end
          endcase
        end
      end
      ST_INIT: begin
        ctl_o.load = 1'b1;
        cnt_d      = CntW'(1);
        q0_d       = EntNone;
        q1_d       = EntNone;
        state_d    = ST_IDLE;
      end
      ST_ALIGN: begin
        // rotate until the first table entry sits at the head
        if (head_i.vld && head_i.first) begin
          state_d = ST_SCAN;
          pos_d   = '0;
        end else begin
          ctl_o.shift = 1'b1;
        end
      end
      ST_SCAN: begin
        ctl_o.shift = 1'b1;
        pos_d       = pos_q + CntW'(1);
        if (merge_q) begin
          if (head_i.vld) begin
            if (q0_q.vld && !q0_q.used && !head_i.used && adj) begin
              q0_d.size = q0_q.size + head_i.size;
              tail_o    = EntNone;
              cnt_d     = cnt_q - CntW'(1);
            end else begin
              tail_o = q0_q;
              q0_d   = head_i;
            end
          end
        end else if (wait_q) begin
          if (head_i.vld) begin
            // resize: matched block in q0, next block at the head
            wait_d = 1'b0;
            if (reqx > q0_q.size) begin
              if (!head_i.used && head_i.size >= diff_up) begin
                qn.size  = reqx;
                xn.start = head_i.start + diff_up;
                xn.size  = head_i.size - diff_up;
                status_d = STATUS_OK;
              end else begin
                status_d = STATUS_NOMEM;
              end
              tail_o = qn;
              q0_d   = xn;
            end else if (reqx < q0_q.size) begin
              if (!head_i.used && adj) begin
                qn.size  = reqx;
                xn.start = head_i.start - diff_dn;
                xn.size  = head_i.size + diff_dn;
                status_d = STATUS_OK;
                tail_o   = qn;
                q0_d     = xn;
              end else if (full) begin
                status_d = STATUS_NOMEM;
                tail_o   = q0_q;
                q0_d     = head_i;
              end else begin
                qn.size  = reqx;
                status_d = STATUS_OK;
                tail_o   = qn;
                q0_d     = rsz_new;
                q1_d     = head_i;
                cnt_d    = cnt_q + CntW'(1);
              end
            end else begin
              status_d = STATUS_OK;
              tail_o   = q0_q;
              q0_d     = head_i;
            end
          end
        end else if (q0_q.vld) begin
          tail_o = q0_q;
          q0_d   = sh_q0;
          q1_d   = sh_q1;
        end else if (head_i.vld && !found_q) begin
          case (op_q)
            OP_ALLOC: begin
              if (fit && (!split || !full)) begin
                xn.used  = 1'b1;
                xn.size  = reqx;
                tail_o   = xn;
                found_d  = 1'b1;
                status_d = STATUS_OK;
                segout_d = head_i.start[15:0];
                if (split) begin
                  q0_d  = alloc_new;
                  cnt_d = cnt_q + CntW'(1);
                end
              end
            end
            OP_FREE: begin
              if (head_i.used && head_i.start == {1'b0, seg_q}) begin
                xn.used  = 1'b0;
                tail_o   = xn;
                found_d  = 1'b1;
                status_d = STATUS_OK;
              end
            end
            OP_RESIZE: begin
              if (head_i.used && head_i.start == {1'b0, seg_q}) begin
                tail_o  = EntNone;
                q0_d    = head_i;
                found_d = 1'b1;
                wait_d  = 1'b1;
              end
            end
            default: begin
              tail_o = head_i;
            end
          endcase
        end
        if (last) begin
          state_d = (!merge_q && wait_d) ? ST_RESOLVE : ST_DRAIN;
        end
      end
      ST_RESOLVE: begin
        // resized block was the last one in the table
        wait_d  = 1'b0;
        state_d = ST_DRAIN;
        if (reqx > q0_q.size) begin
          status_d = STATUS_NOMEM;
        end else if (reqx < q0_q.size) begin
          if (full) begin
            status_d = STATUS_NOMEM;
          end else begin
            q0_d.size = reqx;
            q1_d      = rsz_new;
            cnt_d     = cnt_q + CntW'(1);
            status_d  = STATUS_OK;
          end
        end else begin
          status_d = STATUS_OK;
        end
      end
      ST_DRAIN: begin
        if (q0_q.vld) begin
          ctl_o.shift = 1'b1;
          tail_o      = q0_q;
          q0_d        = sh_q0;
          q1_d        = sh_q1;
        end else if (merge_q) begin
          merge_d = 1'b0;
          state_d = ST_ALIGN;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      merge_q <= 1'b0;
      cnt_q   <= CntW'(1);
      pos_q   <= '0;
      found_q <= 1'b0;
      wait_q  <= 1'b0;
      q0_q    <= EntNone;
      q1_q    <= EntNone;
    end else begin
      state_q <= state_d;
      merge_q <= merge_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      found_q <= found_d;
      wait_q  <= wait_d;
      q0_q    <= q0_d;
      q1_q    <= q1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_cmd) begin
      op_q  <= op_e'(op_i);
      req_q <= size_i;
      seg_q <= seg_i;
    end
    status_q <= status_d;
    segout_q <= segout_d;
  end

  assign busy_o   = state_q != ST_IDLE;
  assign done_o   = state_q == ST_RESP;
  assign status_o = status_q;
  assign seg_o    = segout_q;

endmodule

// ===== hw/rtl/paragraph_first_fit_allocator.sv =====
// Top level of the paragraph allocator: APB register, cell ring, sequencer.
// Depends on pfa_pkg, pfa_cell and pfa_ctrl.
//
// Usage: raise start with opcode_i, size_paras_i and block_segment_i while
// busy is low; the command is taken at that edge. Exactly one result follows,
// shown for one cycle with done_o high, status_o and segment_out_o. The
// receiver cannot hold it off; a new command may be given the cycle after.
// The block table lives in a ring of MaxBlocks cells that rotates one entry a
// cycle past the sequencer while it aligns or scans. A pass first rotates the
// first entry round to the head, then scans the table, then empties the
// sequencer queue. Free takes one pass, allocate and resize two (merge, then
// search).
// Opcode 3 answers in the cycle right after its transfer.
// Reset, or a write of total_paras while idle at an APB address with paddr[2]
// low, rebuilds the table as one free block; busy stays high for that one cycle.
module paragraph_first_fit_allocator import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] size_paras_i,
  input  logic [15:0] block_segment_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] segment_out_o
);

  logic [16:0] total_q, total_d;
  logic        cfg_wr;
  ring_ctl_t   ctl;
  ent_t        tail, init0;
  ent_t        cell_q [MaxBlocks];

  assign pready = 1'b1;
  assign prdata = {15'd0, total_q};
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign total_d = (pwdata[16:0] > TotalMax) ? TotalMax : pwdata[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
    end else if (cfg_wr) begin
      total_q <= total_d;
    end
  end

  always_comb begin
    init0       = EntNone;
    init0.vld   = 1'b1;
    init0.first = 1'b1;
    init0.size  = total_q;
  end

  for (genvar j = 0; j < MaxBlocks; j++) begin : g_cell
    ent_t d, ini;
    if (j == MaxBlocks - 1) begin : g_tail
      assign d = tail;
    end else begin : g_mid
      assign d = cell_q[j+1];
    end
    if (j == 0) begin : g_head
      assign ini = init0;
    end else begin : g_rest
      assign ini = EntNone;
    end
    pfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .init_i (ini),
      .d_i    (d),
      .q_o    (cell_q[j])
    );
  end

  pfa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .start_i  (start),
    .op_i     (opcode_i),
    .size_i   (size_paras_i),
    .seg_i    (block_segment_i),
    .head_i   (cell_q[0]),
    .ctl_o    (ctl),
    .tail_o   (tail),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status_o),
    .seg_o    (segment_out_o)
  );

endmodule

// ===== hw/rtl/pfa_chk.sv =====
// Port-level checks of the paragraph allocator, bound to the top level.
// Depends on paragraph_first_fit_allocator_macros.svh and pfa_pkg.
`include "paragraph_first_fit_allocator_macros.svh"

module pfa_chk import pfa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] segment_out_o
);

  `PFA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after command transfer")
  `PFA_ASSERT_NOW(a_done_busy, done_o, busy, "result while idle")
  `PFA_ASSERT_NXT(a_done_idle, done_o, !busy, "still busy after result")
  `PFA_ASSERT_NOW(a_fail_seg, done_o && status_o != STATUS_OK, segment_out_o == 16'd0,
    "segment set on failure")

endmodule

bind paragraph_first_fit_allocator pfa_chk u_pfa_chk (.*);

// ===== test/tb_paragraph_first_fit_allocator.sv =====
// Self-checking bench for the paragraph first-fit allocator.
// Runs directed and random commands through a table predictor in SystemVerilog.
// Depends on pfa_pkg and paragraph_first_fit_allocator.
`timescale 1ns / 100ps

module tb_paragraph_first_fit_allocator;
  import pfa_pkg::*;

  localparam int NB = MaxBlocks;
  localparam int CycleLimit = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = '0;
  logic [15:0] size_paras_i = '0, block_segment_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] segment_out_o;

  always #1 clk_i = ~clk_i;

  paragraph_first_fit_allocator dut (.*);

  // predicted allocation table
  logic [16:0] tbl_start [NB];
  logic [16:0] tbl_size  [NB];
  logic        tbl_used  [NB];
  int          tbl_count;
  logic [16:0] managed_paras;

  typedef struct packed {
    status_e     status;
    logic [15:0] seg;
  } reply_t;

  reply_t pending_replies[$];
  logic [15:0] live_segs[$];
  int n_cmds, n_replies, n_mismatch;
  longint cycles;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("paragraph_first_fit_allocator: mismatch");
      $finish;
    end
  end

  // checker: compares each completion with the oldest prediction
  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && done_o) begin
      n_replies <= n_replies + 1;
      if (pending_replies.size() == 0) begin
        n_mismatch = n_mismatch + 1;
        if (n_mismatch <= 10) $display("unexpected reply status %0d seg %0h",
                                      status_o, segment_out_o);
      end else begin
        exp_r = pending_replies.pop_front();
        if (status_o !== exp_r.status || segment_out_o !== exp_r.seg) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10)
            $display("reply mismatch: exp status %0d seg %0h, got status %0d seg %0h",
                     exp_r.status, exp_r.seg, status_o, segment_out_o);
        end
      end
    end
  end

  function automatic void table_reset(logic [16:0] total);
    for (int k = 0; k < NB; k++) begin
      tbl_start[k] = '0; tbl_size[k] = '0; tbl_used[k] = 1'b0;
    end
    tbl_count = 1;
    tbl_size[0] = total;
    managed_paras = total;
  endfunction

  function automatic void drop_entry(int idx);
    for (int j = idx; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1]; tbl_size[j] = tbl_size[j+1];
      tbl_used[j] = tbl_used[j+1];
    end
    tbl_count--;
  endfunction

  function automatic void add_free_after(int idx, logic [16:0] s, logic [16:0] sz);
    for (int j = tbl_count; j > idx + 1; j--) begin
      tbl_start[j] = tbl_start[j-1]; tbl_size[j] = tbl_size[j-1];
      tbl_used[j] = tbl_used[j-1];
    end
    tbl_start[idx+1] = s; tbl_size[idx+1] = sz; tbl_used[idx+1] = 1'b0;
    tbl_count++;
  endfunction

  function automatic void coalesce_free();
    int k;
    k = 0;
    while (k + 1 < tbl_count) begin
      if (!tbl_used[k] && !tbl_used[k+1] &&
          tbl_start[k] + tbl_size[k] == tbl_start[k+1]) begin
        tbl_size[k] = tbl_size[k] + tbl_size[k+1];
        drop_entry(k + 1);
      end else k++;
    end
  endfunction

  function automatic int locate_used(logic [16:0] seg);
    for (int k = 0; k < tbl_count; k++)
      if (tbl_used[k] && tbl_start[k] == seg) return k;
    return tbl_count;
  endfunction

  function automatic reply_t run_command(op_e op, logic [15:0] req16, logic [15:0] seg16);
    reply_t r;
    logic [16:0] req, cur, diff;
    int idx, nx;
    req = {1'b0, req16};
    r.status = STATUS_INVALID;
    r.seg = '0;
    case (op)
      OP_ALLOC: begin
        coalesce_free();
        r.status = STATUS_NOMEM;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_used[k] || tbl_start[k] > 17'hFFFF || req > tbl_size[k]) continue;
          if (req < tbl_size[k]) begin
            if (tbl_count >= NB) continue;
            add_free_after(k, tbl_start[k] + req, tbl_size[k] - req);
            tbl_size[k] = req;
          end
          tbl_used[k] = 1'b1;
          r.seg = tbl_start[k][15:0];
          r.status = STATUS_OK;
          break;
        end
      end
      OP_FREE: begin
        idx = locate_used({1'b0, seg16});
        if (idx < tbl_count) begin
          tbl_used[idx] = 1'b0;
          r.status = STATUS_OK;
        end
      end
      OP_RESIZE: begin
        coalesce_free();
        idx = locate_used({1'b0, seg16});
        if (idx < tbl_count) begin
          cur = tbl_size[idx];
          nx = idx + 1;
          r.status = STATUS_OK;
          if (req > cur) begin
            diff = req - cur;
            if (nx >= tbl_count || tbl_used[nx] || tbl_size[nx] < diff)
              r.status = STATUS_NOMEM;
            else begin
              tbl_size[nx] -= diff; tbl_start[nx] += diff; tbl_size[idx] = req;
            end
          end else if (req < cur) begin
            diff = cur - req;
            if (nx < tbl_count && !tbl_used[nx] && tbl_start[idx] + cur == tbl_start[nx]) begin
              tbl_start[nx] -= diff; tbl_size[nx] += diff; tbl_size[idx] = req;
            end else if (tbl_count >= NB) r.status = STATUS_NOMEM;
            else begin
              add_free_after(idx, tbl_start[idx] + req, diff);
              tbl_size[idx] = req;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue_command(op_e op, logic [15:0] req, logic [15:0] seg, bit pace = 1);
    reply_t r;
    int gap;
    gap = pace ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b1;
    opcode_i <= op; size_paras_i <= req; block_segment_i <= seg;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // transfer taken at this edge
    r = run_command(op, req, seg);
    pending_replies.push_back(r);
    if (op == OP_ALLOC && r.status == STATUS_OK) live_segs.push_back(r.seg);
    n_cmds++;
    start <= 1'b0;
    // busy is high for at least this cycle, so nothing is lost by waiting
    @(posedge clk_i);
  endtask

  task automatic drain_replies();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_total(logic [31:0] v);
    logic [16:0] sat;
    drain_replies();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sat = (v[16:0] > TotalMax) ? TotalMax : v[16:0];
    table_reset(sat);
    live_segs.delete();
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_segment();
    if (live_segs.size() != 0 && $urandom_range(0, 9) != 0)
      return live_segs[$urandom_range(0, live_segs.size() - 1)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    issue_command(OP_ALLOC, 16'd0, 16'd0);        // zero-size block
    issue_command(OP_ALLOC, 16'd100, 16'd0);
    issue_command(OP_ALLOC, 16'hFFFF, 16'd0);     // too large for reset size
    issue_command(OP_FREE, 16'd0, 16'd1234);      // unknown block
    issue_command(OP_RESIZE, 16'd200, 16'd0);     // grow the zero-size block, neighbour is used
    issue_command(OP_RESIZE, 16'd50, 16'd0);      // grow the zero-size block again, neighbour is used
    issue_command(OP_RESIZE, 16'd10, 16'hBEEF);   // unknown block, merge still runs
    issue_command(OP_BAD, 16'hFFFF, 16'hFFFF);
    issue_command(OP_FREE, 16'd0, 16'd0);
    issue_command(OP_ALLOC, 16'd40960, 16'd0);
    write_total(32'h0001_FFFF);                   // saturates
    issue_command(OP_ALLOC, 16'hFFFF, 16'd0);
    issue_command(OP_ALLOC, 16'd1, 16'd0);
    issue_command(OP_ALLOC, 16'd1, 16'd0);        // no free block left
    issue_command(OP_RESIZE, 16'd2, 16'hFFFF);    // no free neighbour
    write_total(32'd0);
    issue_command(OP_ALLOC, 16'd0, 16'd0);
    issue_command(OP_ALLOC, 16'd1, 16'd0);
    write_total(32'd200);
    // fill the table so that only exact fits succeed
    for (int k = 0; k < 66; k++) issue_command(OP_ALLOC, 16'd1, 16'd0, 0);
    issue_command(OP_FREE, 16'd0, 16'd5);
    issue_command(OP_RESIZE, 16'd0, 16'd7);       // shrink with full table
    issue_command(OP_ALLOC, 16'd1, 16'd0);
    drain_replies();                              // sender holds off until all replies are in
  endtask

  task automatic test_random(int count, logic [31:0] total);
    int roll;
    op_e op;
    logic [15:0] req;
    write_total(total);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      op = roll < 45 ? OP_ALLOC : roll < 75 ? OP_FREE : roll < 97 ? OP_RESIZE : OP_BAD;
      case ($urandom_range(0, 9))
        0: req = 16'($urandom);
        1: req = 16'hFFFF;
        2: req = '0;
        default: req = 16'($urandom_range(1, total > 2000 ? 600 : 40));
      endcase
      issue_command(op, req, op == OP_ALLOC ? 16'($urandom) : pick_segment(),
                    k % 200 < 150);
    end
  endtask

  initial begin
    cycles = 0; n_cmds = 0; n_replies = 0; n_mismatch = 0;
    table_reset(TotalReset);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 32'd40960);
    test_random(400, 32'd300);
    test_random(400, 32'd65536);
    test_random(300, 32'd1);
    test_random(100, 32'd5000);
    drain_replies();
    repeat (400) @(posedge clk_i);
    $display("%0d commands sent, %0d replies checked, %0d mismatches", n_cmds, n_replies,
             n_mismatch);
    $display("table sizes 0 to 65536 exercised, including full-table behaviour");
    if (n_mismatch == 0 && pending_replies.size() == 0)
      $display("paragraph_first_fit_allocator: match");
    else
      $display("paragraph_first_fit_allocator: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_cell.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/paragraph_first_fit_allocator.sv
hw/rtl/pfa_chk.sv
test/tb_paragraph_first_fit_allocator.sv
